// File: src/lst_pkg.sv
// Shared types, sizes and codes for the ordered list block.
`timescale 1ns / 1ps

package lst_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef logic signed [31:0] word_t;

  // Request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ELEMENT   = 2'd0;
  localparam logic [1:0] ST_NOW_EMPTY = 2'd1;
  localparam logic [1:0] ST_DEL_EMPTY = 2'd2;
  localparam logic [1:0] ST_APP_FULL  = 2'd3;

  // Cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

// File: src/lst_cell.sv
// One storage cell of the list chain; takes data from its right neighbor, the new item or the head.
`timescale 1ns / 1ps

module lst_cell
  import lst_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  word_t            right_value,
  input  word_t            head_value,
  input  word_t            item_value,
  output word_t            value
);

  logic [CNT_W-1:0] idx_ext;
  logic             is_tail;
  logic             is_free;
  logic             at_or_past_pos;

  assign idx_ext        = CNT_W'(idx);
  assign is_tail        = (idx_ext + CNT_W'(1)) == ctrl.count;
  assign is_free        = idx_ext == ctrl.count;
  assign at_or_past_pos = 8'(idx) >= ctrl.pos;

  // Load at the first free slot, close a gap, or rotate the live run by one
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (is_free) value <= item_value;
      end
      OP_SHIFT: begin
        if (at_or_past_pos) value <= right_value;
      end
      OP_ROTATE: begin
        value <= is_tail ? head_value : right_value;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

// File: src/lst_ctrl.sv
// Request sequencer: entry count, cell commands and the result register.
`timescale 1ns / 1ps

module lst_ctrl
  import lst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       req_type,
  input  logic [7:0] position,
  input  word_t      head_value,
  output logic       busy,
  output cell_ctrl_t ctrl,
  output logic       out_valid,
  output word_t      element_value,
  output logic [1:0] status,
  output logic       last_of_run
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remain;
  logic             take;
  logic             full;
  logic             empty;

  assign busy  = state == S_STREAM;
  assign take  = start && (state == S_IDLE);
  assign full  = count == FULL_COUNT;
  assign empty = count == '0;

  // Command for the cell row
  always_comb begin
    ctrl.pos   = position;
    ctrl.count = count;
    ctrl.op    = OP_HOLD;
    if (state == S_STREAM) begin
      ctrl.op = OP_ROTATE;
    end else if (take) begin
      if (req_type == REQ_APPEND && !full) ctrl.op = OP_LOAD;
      else if (req_type == REQ_DELETE && !empty) ctrl.op = OP_SHIFT;
    end
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (req_type == REQ_APPEND) begin
              if (full) begin
                out_valid     <= 1'b1;
                element_value <= '0;
                status        <= ST_APP_FULL;
                last_of_run   <= 1'b1;
              end else begin
                count <= count + CNT_W'(1);
              end
            end else if (empty) begin
              out_valid     <= 1'b1;
              element_value <= '0;
              status        <= ST_DEL_EMPTY;
              last_of_run   <= 1'b1;
            end else begin
              count <= count - CNT_W'(1);
              if (count == CNT_W'(1)) begin
                out_valid     <= 1'b1;
                element_value <= '0;
                status        <= ST_NOW_EMPTY;
                last_of_run   <= 1'b1;
              end else begin
                remain <= count - CNT_W'(1);
                state  <= S_STREAM;
              end
            end
          end
        end
        S_STREAM: begin
          // Head leaves the chain each cycle while the run rotates
          out_valid     <= 1'b1;
          element_value <= head_value;
          status        <= ST_ELEMENT;
          last_of_run   <= remain == CNT_W'(1);
          remain        <= remain - CNT_W'(1);
          if (remain == CNT_W'(1)) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/list_delete_at_position.sv
// Top level: ordered list with tail append and delete at a position.
//
// Requests enter on start/busy: a request is taken at a clock edge where start
// is high and busy is low. req_type selects append (item_value goes to the
// tail) or delete (the element at position leaves; a position at or past the
// tail removes the tail). Results leave on out_valid with element_value,
// status and last_of_run, each for exactly one cycle; the receiver cannot
// stall them and must take every one.
// An append gives no result, or one full-status result in the next cycle.
// A delete on an empty list, or one that empties the list, gives one status
// result in the next cycle. Any other delete shifts the cells and enters the
// streaming state; the result register then takes the n remaining elements
// from the head, one per cycle; busy stays high until the last is registered.
// The rate is set by the cell chain, which rotates the live run by one place
// per cycle to bring each element to the head.
// Reset empties the list and drops out_valid; storage contents are not
// cleared since unused cells are never read.
`timescale 1ns / 1ps

module list_delete_at_position
  import lst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  word_t       item_value,
  input  logic [7:0]  position,
  output logic        out_valid,
  output word_t       element_value,
  output logic [1:0]  status,
  output logic        last_of_run
);

  cell_ctrl_t ctrl;
  word_t      cell_value [DEPTH];

  lst_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .position      (position),
    .head_value    (cell_value[0]),
    .busy          (busy),
    .ctrl          (ctrl),
    .out_valid     (out_valid),
    .element_value (element_value),
    .status        (status),
    .last_of_run   (last_of_run)
  );

  // Row of cells; each reads its right neighbor, the last reads itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lst_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .ctrl        (ctrl),
      .right_value (cell_value[(i + 1 < DEPTH) ? i + 1 : i]),
      .head_value  (cell_value[0]),
      .item_value  (item_value),
      .value       (cell_value[i])
    );
  end

  // Status results are always single and marked last
  a_status_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ELEMENT) |-> last_of_run)
    else $error("status result not marked last");

  // A taken delete either streams or reports at once
  a_delete_answers : assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_DELETE) |=> busy || out_valid)
    else $error("delete produced no activity");

  // Nothing follows the last result of a run unless a new request was taken
  a_gap_after_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run && !(start && !busy) |=> !out_valid)
    else $error("result after last of run");

  // Entry count stays within capacity
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    ctrl.count <= FULL_COUNT)
    else $error("entry count past capacity");

endmodule

// File: tb/sv/tb_list_delete_at_position.sv
// Testbench for the ordered list block: random and directed appends and deletes, checked.
`timescale 1ns / 1ps

module tb_list_delete_at_position;
  import lst_pkg::*;

  // One request as the sender presents it
  typedef struct {
    logic       req;
    word_t      val;
    logic [7:0] pos;
  } list_req_t;

  // One result as the block reports it
  typedef struct {
    word_t      val;
    logic [1:0] st;
    logic       last;
  } list_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       req_type = REQ_APPEND;
  word_t      item_value = '0;
  logic [7:0] position = '0;
  logic       out_valid;
  word_t      element_value;
  logic [1:0] status;
  logic       last_of_run;

  list_req_t    request_queue[$];
  list_result_t expected_results[$];

  // Shadow copy of the list contents and length
  word_t shadow_list[DEPTH];
  int    shadow_count = 0;

  // Length as the stimulus generator sees it, used only to shape requests
  int gen_count = 0;
  int total_requests = 0;
  int accepted_requests = 0;
  int error_count = 0;

  // Sender burst/gap pacing
  int burst_left = 1;
  int gap_left = 0;
  list_req_t next_req;
  list_result_t got;

  list_delete_at_position dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .item_value    (item_value),
    .position      (position),
    .out_valid     (out_valid),
    .element_value (element_value),
    .status        (status),
    .last_of_run   (last_of_run)
  );

  always #5 clk = ~clk;

  function automatic void expect_result(word_t v, logic [1:0] s, logic l);
    list_result_t r;
    r.val = v;
    r.st = s;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  // Update the shadow list for one taken request and queue the results it causes
  function automatic void apply_request(list_req_t r);
    int idx;
    if (r.req == REQ_APPEND) begin
      if (shadow_count >= DEPTH) begin
        expect_result('0, ST_APP_FULL, 1'b1);
      end else begin
        shadow_list[shadow_count] = r.val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      expect_result('0, ST_DEL_EMPTY, 1'b1);
    end else begin
      // positions at or past the last index remove the tail
      idx = (int'(r.pos) >= shadow_count - 1) ? shadow_count - 1 : int'(r.pos);
      for (int i = idx; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_count--;
      if (shadow_count == 0) begin
        expect_result('0, ST_NOW_EMPTY, 1'b1);
      end else begin
        for (int i = 0; i < shadow_count; i++)
          expect_result(shadow_list[i], ST_ELEMENT, i == shadow_count - 1);
      end
    end
  endfunction

  // Queue a request for the driver and track the list length it will leave
  task automatic add_request(logic rq, word_t v, logic [7:0] p);
    list_req_t r;
    r.req = rq;
    r.val = v;
    r.pos = p;
    request_queue.push_back(r);
    total_requests++;
    if (rq == REQ_APPEND) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic word_t rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Half the time a position within or just past the list, else anywhere in the field
  function automatic logic [7:0] rand_pos();
    if (gen_count > 0 && $urandom_range(0, 1) == 0) return 8'($urandom_range(0, gen_count));
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: present queued requests in bursts, hold while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_req.req = req_type;
        next_req.val = item_value;
        next_req.pos = position;
        apply_request(next_req);
        accepted_requests++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_queue.size() > 0) begin
          next_req = request_queue.pop_front();
          start <= 1'b1;
          req_type <= next_req.req;
          item_value <= next_req.val;
          position <= next_req.pos;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d last %0b",
                 $time, element_value, status, last_of_run);
        error_count++;
      end else begin
        got = expected_results.pop_front();
        if (element_value !== got.val) begin
          $display("%0t: element_value expected %0d got %0d", $time, got.val, element_value);
          error_count++;
        end
        if (status !== got.st) begin
          $display("%0t: status expected %0d got %0d", $time, got.st, status);
          error_count++;
        end
        if (last_of_run !== got.last) begin
          $display("%0t: last_of_run expected %0b got %0b", $time, got.last, last_of_run);
          error_count++;
        end
      end
    end
  end

  // Stimulus, then drain and verdict
  initial begin
    int n_random;
    int mode;
    int len;

    // Directed: empty deletes, extreme values, head/middle/tail/past-end deletes
    add_request(REQ_DELETE, '0, 8'd0);
    add_request(REQ_DELETE, 32'sh1234_5678, 8'd255);
    add_request(REQ_APPEND, 32'sh8000_0000, 8'd255);
    add_request(REQ_APPEND, 32'sh7fff_ffff, 8'd0);
    add_request(REQ_APPEND, '0, 8'd17);
    add_request(REQ_APPEND, -32'sd1, 8'd0);
    add_request(REQ_APPEND, 32'sh5555_5555, 8'd170);
    add_request(REQ_APPEND, 32'shaaaa_aaaa, 8'd85);
    add_request(REQ_DELETE, 32'shffff_ffff, 8'd255);
    add_request(REQ_DELETE, '0, 8'd0);
    add_request(REQ_DELETE, '0, 8'd1);
    add_request(REQ_DELETE, '0, 8'd2);
    add_request(REQ_DELETE, '0, 8'd200);
    add_request(REQ_DELETE, '0, 8'd0);
    add_request(REQ_DELETE, '0, 8'd0);
    add_request(REQ_APPEND, 32'sh0000_0001, 8'd0);
    add_request(REQ_APPEND, 32'sh8000_0001, 8'd0);
    add_request(REQ_DELETE, '0, 8'd1);
    add_request(REQ_DELETE, '0, 8'd0);

    // Random episodes: fill to full, drain to empty, or mixed traffic
    n_random = 0;
    while (n_random < 450) begin
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        while (gen_count < DEPTH) begin
          if ($urandom_range(0, 9) == 0) add_request(REQ_DELETE, word_t'($urandom), rand_pos());
          else add_request(REQ_APPEND, rand_value(), 8'($urandom));
          n_random++;
        end
        len = $urandom_range(1, 3);
        repeat (len) add_request(REQ_APPEND, rand_value(), 8'($urandom));
        n_random += len;
      end else if (mode == 1) begin
        while (gen_count > 0) begin
          add_request(REQ_DELETE, word_t'($urandom), rand_pos());
          n_random++;
        end
        len = $urandom_range(1, 2);
        repeat (len) add_request(REQ_DELETE, word_t'($urandom), 8'($urandom));
        n_random += len;
      end else begin
        len = $urandom_range(20, 40);
        repeat (len) begin
          if ($urandom_range(0, 99) < 55) add_request(REQ_APPEND, rand_value(), 8'($urandom));
          else add_request(REQ_DELETE, word_t'($urandom), rand_pos());
        end
        n_random += len;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_requests < total_requests) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: list_delete_at_position.f
src/lst_pkg.sv
src/lst_cell.sv
src/lst_ctrl.sv
src/list_delete_at_position.sv
tb/sv/tb_list_delete_at_position.sv
